@@ rtl/sfd_pkg.sv @@
// shared constants and types of the sensor frame deframer
package sfd_pkg;

  localparam int NUM_FIELDS  = 4;
  localparam int FIELD_CHARS = 4;
  localparam int BYTE_W      = 8;
  localparam int FIELD_W     = FIELD_CHARS * BYTE_W;
  localparam int PAYLOAD_LEN = NUM_FIELDS * FIELD_CHARS;
  localparam int WINDOW_LEN  = PAYLOAD_LEN + 1;
  localparam int EXACT_LEN   = PAYLOAD_LEN + 2;
  localparam int LEN_SAT     = PAYLOAD_LEN + 3;
  localparam int LEN_W       = $clog2(LEN_SAT + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TERMINATOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MARKER     = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] TERMINATOR_RST = BYTE_W'(101);
  localparam logic [BYTE_W-1:0] MARKER_RST     = BYTE_W'(102);

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                                frame_ok;
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] field;
  } frame_result_t;

endpackage

@@ rtl/sensor_frame_deframer_top.sv @@
// top level of the sensor frame deframer
//
// in_*  : one received byte per word (in_rx_byte), valid/ready handshake.
// out_* : one result word per terminator byte: out_frame_ok and four
//         32-bit fields, earliest character in the most significant byte;
//         a rejected frame gives frame_ok low and all fields zero.
// cfg_* : register writes, index 0 terminator byte, index 1 marker byte,
//         other indexes ignored; cfg_ready is always high.
// throughput: one byte per cycle unless the queue is full, terminator bytes
//   included, set by the window shift and the parallel marker compares.
// path: a terminator's result word is written into the queue as the
//   terminator is taken, then moves into the output register once that
//   register is empty or being read; out_valid comes from that register.
// reset: length count cleared, terminator back to 'e', marker back to 'f',
//   queue and output register empty; the byte window is not cleared.
// stall: a held result sits in the output register and two more in the
//   two-entry queue; in_ready drops for every byte once the queue is full.
module sensor_frame_deframer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_frame_ok,
  output logic [sfd_pkg::FIELD_W-1:0]    out_field_zero,
  output logic [sfd_pkg::FIELD_W-1:0]    out_field_one,
  output logic [sfd_pkg::FIELD_W-1:0]    out_field_two,
  output logic [sfd_pkg::FIELD_W-1:0]    out_field_three
);

  logic                    q_full;
  logic                    push_valid;
  sfd_pkg::frame_result_t  push_data;
  logic                    q_valid;
  logic                    q_ready;
  sfd_pkg::frame_result_t  q_data;
  sfd_pkg::frame_result_t  out_data;

  assign cfg_ready = 1'b1;

  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  sfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  sfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_frame_ok    = out_data.frame_ok;
  assign out_field_zero  = out_data.field[0];
  assign out_field_one   = out_data.field[1];
  assign out_field_two   = out_data.field[2];
  assign out_field_three = out_data.field[3];

endmodule

@@ rtl/sfd_front.sv @@
// front part: config registers, byte window, length count and frame check
module sfd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic                               q_full,
  output logic                               push_valid,
  output sfd_pkg::frame_result_t             push_data
);

  sfd_pkg::byte_t             terminator_r;
  sfd_pkg::byte_t             marker_r;
  sfd_pkg::byte_t             window_r [sfd_pkg::WINDOW_LEN];
  logic [sfd_pkg::LEN_W-1:0]  len_r;
  logic [sfd_pkg::LEN_W-1:0]  len_nxt;

  logic in_acc;
  logic is_term;
  logic tail_has_marker;
  logic frame_ok;

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;
  assign is_term  = (in_rx_byte == terminator_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terminator_r <= sfd_pkg::TERMINATOR_RST;
      marker_r     <= sfd_pkg::MARKER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfd_pkg::CFG_IDX_TERMINATOR: terminator_r <= cfg_wdata;
        sfd_pkg::CFG_IDX_MARKER:     marker_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window shifts toward index 0, newest byte at the top
  always_ff @(posedge clk) begin
    if (in_acc && !is_term) begin
      for (int i = 0; i < sfd_pkg::WINDOW_LEN - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[sfd_pkg::WINDOW_LEN-1] <= in_rx_byte;
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (in_acc) begin
      if (is_term) begin
        len_nxt = '0;
      end else if (len_r != sfd_pkg::LEN_W'(sfd_pkg::LEN_SAT)) begin
        len_nxt = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_comb begin
    tail_has_marker = 1'b0;
    for (int i = 1; i < sfd_pkg::WINDOW_LEN; i++) begin
      tail_has_marker = tail_has_marker | (window_r[i] == marker_r);
    end
  end

  always_comb begin
    if (len_r == sfd_pkg::LEN_W'(sfd_pkg::EXACT_LEN)) begin
      frame_ok = 1'b1;
    end else if (len_r > sfd_pkg::LEN_W'(sfd_pkg::EXACT_LEN)) begin
      frame_ok = (window_r[0] == marker_r) && !tail_has_marker;
    end else begin
      frame_ok = 1'b0;
    end
  end

  always_comb begin
    push_data.frame_ok = frame_ok;
    for (int k = 0; k < sfd_pkg::NUM_FIELDS; k++) begin
      for (int c = 0; c < sfd_pkg::FIELD_CHARS; c++) begin
        push_data.field[k][(sfd_pkg::FIELD_CHARS-1-c)*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] =
          frame_ok ? window_r[1 + k*sfd_pkg::FIELD_CHARS + c] : '0;
      end
    end
  end

  assign push_valid = in_acc && is_term;

`ifndef ASSERT_OFF
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= sfd_pkg::LEN_W'(sfd_pkg::LEN_SAT))
    else $error("frame length above saturation");
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |=> (len_r == '0))
    else $error("terminator did not clear length");
`endif

endmodule

@@ rtl/sfd_queue.sv @@
// short result queue between front and back
module sfd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  input  sfd_pkg::frame_result_t  push_data,
  output logic                    full,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output sfd_pkg::frame_result_t  pop_data
);

  sfd_pkg::frame_result_t        mem_r [sfd_pkg::Q_DEPTH];
  logic [sfd_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [sfd_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [sfd_pkg::Q_CNT_W-1:0]   cnt_r;
  logic [sfd_pkg::Q_CNT_W-1:0]   cnt_nxt;
  logic                          push;
  logic                          pop;

  assign full      = (cnt_r == sfd_pkg::Q_CNT_W'(sfd_pkg::Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == sfd_pkg::Q_PTR_W'(sfd_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == sfd_pkg::Q_PTR_W'(sfd_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("word pushed into full queue");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not rise on push");
  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not fall on pop");
`endif

endmodule

@@ rtl/sfd_back.sv @@
// back part: output register that drives the result channel
module sfd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  sfd_pkg::frame_result_t  q_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sfd_pkg::frame_result_t  out_data
);

  logic                    out_valid_r;
  sfd_pkg::frame_result_t  out_data_r;

  assign q_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      out_data_r <= q_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
